### rtl/core/double_ended_queue_macros.svh
// assertion macros shared by the double-ended queue rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, off while in reset
`define DQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/dq_pkg.sv
// types and constants of the double-ended queue
// no dependencies
package dq_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_DONE  = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;     // word accepted this cycle
		logic capture;  // load popped word from the slot store
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic needs_read;  // current request is a pop on a nonempty queue
	} dp_sts_t;

endpackage

### rtl/core/dq_in_if.sv
// request channel of the double-ended queue
// depends on dq_pkg
interface dq_in_if;
	import dq_pkg::*;

	logic                     valid;
	logic                     ready;
	op_t                      op;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink   (input valid, input op, input push_value, output ready);

endinterface

### rtl/core/dq_out_if.sv
// response channel of the double-ended queue
// depends on dq_pkg
interface dq_out_if #(
	parameter int DEPTH = 16
);
	import dq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic signed [DATA_W-1:0] popped_value;
	logic [CNT_W-1:0]         occupancy;

	modport source (output valid, output status, output popped_value, output occupancy,
		input ready);
	modport sink   (input valid, input status, input popped_value, input occupancy,
		output ready);

endinterface

### rtl/core/dq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/core/dq_datapath.sv
// datapath of the double-ended queue: ring indices, slot store, result register
// depends on dq_pkg, dq_ram and double_ended_queue_macros.svh
`include "double_ended_queue_macros.svh"

module dq_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dq_pkg::op_t                      op,
	input  logic signed [dq_pkg::DATA_W-1:0] push_value,
	input  dq_pkg::ctrl_cmd_t                cmd,
	output dq_pkg::dp_sts_t                  sts,
	output dq_pkg::status_t                  status,
	output logic signed [dq_pkg::DATA_W-1:0] popped_value,
	output logic [$clog2(DEPTH+1)-1:0]       occupancy
);
	import dq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	logic [IDX_W-1:0]  front_q;
	logic [CNT_W-1:0]  count_q;
	status_t           status_q;
	logic [DATA_W-1:0] popped_q;
	logic [CNT_W-1:0]  occ_q;

	logic              is_push;
	logic              full;
	logic              empty;
	logic [IDX_W-1:0]  front_inc;
	logic [IDX_W-1:0]  front_dec;
	logic [SUM_W-1:0]  rear_sum;
	logic [SUM_W-1:0]  last_sum;
	logic [IDX_W-1:0]  rear_pos;
	logic [IDX_W-1:0]  last_pos;
	logic              wr_en;
	logic              rd_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  rd_addr;
	logic [DATA_W-1:0] rd_data;
	logic [CNT_W-1:0]  count_d;
	logic [IDX_W-1:0]  front_d;
	status_t           status_d;

	assign is_push = (op == OP_PUSH_FRONT) || (op == OP_PUSH_REAR);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);

	assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + IDX_W'(1);
	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);

	// slot past the rear, and the rear slot itself, wrapped by one subtract
	assign rear_sum = SUM_W'(front_q) + SUM_W'(count_q);
	assign last_sum = rear_sum - SUM_W'(1);
	assign rear_pos = (rear_sum >= SUM_W'(DEPTH)) ? IDX_W'(rear_sum - SUM_W'(DEPTH))
		: IDX_W'(rear_sum);
	assign last_pos = (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
		: IDX_W'(last_sum);

	assign wr_en   = cmd.take && is_push && !full;
	assign rd_en   = cmd.take && !is_push && !empty;
	assign wr_addr = (op == OP_PUSH_FRONT) ? front_dec : rear_pos;
	assign rd_addr = (op == OP_POP_FRONT) ? front_q : last_pos;

	assign sts.needs_read = !is_push && !empty;

	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		status_d = STS_DONE;
		case (op)
			OP_PUSH_FRONT: begin
				if (full) begin
					status_d = STS_FULL;
				end else begin
					front_d = front_dec;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_PUSH_REAR: begin
				if (full) begin
					status_d = STS_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = STS_EMPTY;
				end else begin
					front_d = front_inc;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_POP_REAR: begin
				if (empty) begin
					status_d = STS_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = STS_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.take) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	// result register, popped word filled in the following cycle from the registered store read
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			status_q <= status_d;
			occ_q    <= count_d;
			popped_q <= '0;
		end else if (cmd.capture) begin
			popped_q <= rd_data;
		end
	end

	dq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (push_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign status       = status_q;
	assign popped_value = $signed(popped_q);
	assign occupancy    = occ_q;

	`DQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "count above depth")
	`DQ_ASSERT_NEXT(a_refused_holds,
		cmd.take && ((is_push && full) || (!is_push && empty)),
		$stable(count_q) && $stable(front_q),
		"refused op changed queue state")
	`DQ_ASSERT_NEXT(a_rear_push,
		cmd.take && (op == OP_PUSH_REAR) && !full,
		$stable(front_q) && (count_q == $past(count_q) + CNT_W'(1)),
		"rear push moved front or missed count")
	`DQ_ASSERT_IMPL(a_one_port_op, 1'b1, !(wr_en && rd_en), "slot read and write in one cycle")

endmodule

### rtl/core/dq_ctrl.sv
// controller of the double-ended queue: handshakes and sequencing of a word
// depends on dq_pkg
module dq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  dq_pkg::dp_sts_t   sts,
	output dq_pkg::ctrl_cmd_t cmd
);
	import dq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   take;

	assign take = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					state_d = sts.needs_read ? ST_READ : ST_RESP;
				end
			end
			ST_READ: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (take) begin
					state_d = sts.needs_read ? ST_READ : ST_RESP;
				end else if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.capture = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_READ: begin
				cmd.capture = 1'b1;
			end
			ST_RESP: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.take = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/double_ended_queue.sv
// double-ended queue of signed words in a ring store, one response word per request
// response: registered when a request is taken; a pop first waits on the registered slot read
// throughput: pushes 1 per cycle while rsp.ready holds; no request is taken while a pop reads
// reset: arst_n clears front index, count and controller at once; queue comes up empty
// slot store is not cleared, a pop only ever reads a slot that a push has written
// depends on dq_pkg, dq_in_if, dq_out_if, dq_datapath, dq_ctrl
module double_ended_queue #(
	parameter int DEPTH = 16
) (
	input logic      clk,
	input logic      arst_n,
	dq_in_if.sink    req,
	dq_out_if.source rsp
);
	import dq_pkg::*;

	// controller and datapath talk only through these two groups
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// handshake sequencing: idle, wait on slot read, hold response
	// a new request word is taken while the held response leaves
	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// ring indices, slot ram and the response register
	// the front index and count move on the cycle a request is taken
	dq_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (req.op),
		.push_value   (req.push_value),
		.cmd          (cmd),
		.sts          (sts),
		.status       (rsp.status),
		.popped_value (rsp.popped_value),
		.occupancy    (rsp.occupancy)
	);

endmodule

### verif/double_ended_queue_tb.sv
// self-checking testbench of the double-ended queue: directed corner words, then biased random walks
// depends on dq_pkg, dq_in_if, dq_out_if and double_ended_queue
module double_ended_queue_tb;
	import dq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// one expected response word
	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] popped_value;
		logic [CNT_W-1:0]         occupancy;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n;

	dq_in_if                  req_if ();
	dq_out_if #(.DEPTH(DEPTH)) rsp_if ();

	double_ended_queue #(.DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the deque: ring store, front index and word count
	logic signed [DATA_W-1:0] shadow_ring [DEPTH];
	int                       shadow_front;
	int                       shadow_count;

	// responses predicted but not yet seen, oldest first
	deque_result_t pending_results [$];

	int  error_count;
	bit  src_steady;   // no gaps between request words
	bit  sink_steady;  // no stalls on the response side

	// apply one request to the shadow deque and return the response it must produce
	function automatic deque_result_t predict_deque_op(op_t op, logic signed [DATA_W-1:0] value);
		deque_result_t res;
		int            pos;
		res.status       = STS_DONE;
		res.popped_value = '0;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (shadow_count >= DEPTH) begin
					// full store refuses the push, nothing moves
					res.status = STS_FULL;
				end else if (op == OP_PUSH_FRONT) begin
					shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
					shadow_ring[shadow_front] = value;
					shadow_count++;
				end else begin
					pos = (shadow_front + shadow_count) % DEPTH;
					shadow_ring[pos] = value;
					shadow_count++;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					// pop on empty reports empty and leaves the state alone
					res.status = STS_EMPTY;
				end else if (op == OP_POP_FRONT) begin
					res.popped_value = shadow_ring[shadow_front];
					shadow_front = (shadow_front + 1) % DEPTH;
					shadow_count--;
				end else begin
					pos = (shadow_front + shadow_count - 1) % DEPTH;
					res.popped_value = shadow_ring[pos];
					shadow_count--;
				end
			end
		endcase
		res.occupancy = CNT_W'(shadow_count);
		return res;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(3, 1);
		else
			return $urandom_range(40, 10);
	endfunction

	// present one request word and wait until it is taken; predict on acceptance
	task automatic send_request(input op_t op, input logic signed [DATA_W-1:0] value);
		int gap;
		gap = src_steady ? 0 : pick_idle_len();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.op         <= op;
		req_if.push_value <= value;
		do
			@(posedge clk);
		while (!req_if.ready);
		pending_results.push_back(predict_deque_op(op, value));
	endtask

	// push value: a share of corner words, otherwise fully random
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(19))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -32'sd1;
			3: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	// pops on an empty queue, from both ends
	task automatic test_empty_pops();
		send_request(OP_POP_FRONT, 32'sh5a5a_a5a5);
		send_request(OP_POP_REAR, -32'sd1);
	endtask

	// corner words in at both ends, out again at both ends
	task automatic test_extreme_words();
		send_request(OP_PUSH_FRONT, 32'sh8000_0000);
		send_request(OP_PUSH_REAR, 32'sh7fff_ffff);
		send_request(OP_PUSH_REAR, -32'sd1);
		send_request(OP_PUSH_FRONT, 32'sd0);
		send_request(OP_POP_FRONT, 32'sd0);
		send_request(OP_POP_REAR, 32'sh7fff_ffff);
		send_request(OP_POP_REAR, 32'sh8000_0000);
		send_request(OP_POP_FRONT, -32'sd1);
	endtask

	// fill the store across the wrap point, then push onto it at both ends
	task automatic test_full_refusal();
		for (int i = 0; i < DEPTH; i++)
			send_request((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR, $urandom);
		send_request(OP_PUSH_FRONT, 32'sh1234_5678);
		send_request(OP_PUSH_REAR, -32'sd2);
	endtask

	// random walk whose push share steers the queue toward full or toward empty
	task automatic test_random_walk(input int n_items, input int push_pct, input bit steady);
		op_t op;
		src_steady  = steady;
		sink_steady = steady;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(99) < push_pct)
				op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
			else
				op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
			send_request(op, pick_value());
		end
		src_steady  = 1'b0;
		sink_steady = 1'b0;
	endtask

	// response side: random stalls on ready, check every word taken
	initial begin
		int stall_left;
		int r;
		deque_result_t want;
		stall_left = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) begin
				if (pending_results.size() == 0) begin
					$error("response word with nothing expected");
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (rsp_if.status !== want.status) begin
						$error("status: expected %0d actual %0d", want.status, rsp_if.status);
						error_count++;
					end
					if (rsp_if.popped_value !== want.popped_value) begin
						$error("popped_value: expected %0d actual %0d",
							want.popped_value, rsp_if.popped_value);
						error_count++;
					end
					if (rsp_if.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d actual %0d",
							want.occupancy, rsp_if.occupancy);
						error_count++;
					end
				end
			end
			// next ready value, one assignment per edge
			if (sink_steady) begin
				rsp_if.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				r = $urandom_range(99);
				if (r < 70) begin
					rsp_if.ready <= 1'b1;
				end else if (r < 95) begin
					stall_left = $urandom_range(2);
					rsp_if.ready <= 1'b0;
				end else begin
					stall_left = $urandom_range(40, 10);
					rsp_if.ready <= 1'b0;
				end
			end
		end
	end

	// stimulus sequence
	initial begin
		error_count  = 0;
		src_steady   = 1'b0;
		sink_steady  = 1'b0;
		shadow_front = 0;
		shadow_count = 0;
		arst_n            <= 1'b0;
		req_if.valid      <= 1'b0;
		req_if.op         <= OP_PUSH_FRONT;
		req_if.push_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pops();
		test_extreme_words();
		test_full_refusal();

		// alternate toward full and toward empty so both refusals recur
		test_random_walk(325, 85, 1'b0);
		test_random_walk(325, 15, 1'b0);
		test_random_walk(325, 50, 1'b1);
		test_random_walk(325, 80, 1'b0);
		test_random_walk(325, 20, 1'b0);
		test_random_walk(325, 50, 1'b0);

		req_if.valid <= 1'b0;

		// drain outstanding responses, then a few quiet cycles
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
